// ===== sv/lazy_range_add_range_max_tree_assert.svh =====
// assertion macros for the lazy range-add / range-max tree
`ifndef LAZY_RANGE_ADD_RANGE_MAX_TREE_ASSERT_SVH
`define LAZY_RANGE_ADD_RANGE_MAX_TREE_ASSERT_SVH

`ifndef ASSERT_OFF
// antecedent in this cycle implies consequent in the next cycle
`define LRM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define LRM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define LRM_ASSERT_NEXT(lbl, ante, cons)
`define LRM_ASSERT_NOW(lbl, ante, cons)
`endif

`endif

// ===== sv/lrm_pkg.sv =====
package lrm_pkg;

	localparam int MAX_LEAVES  = 1024;
	localparam int POS_W       = 11;
	localparam int NODE_DEPTH  = 2 * MAX_LEAVES;
	localparam int NODE_AW     = $clog2(NODE_DEPTH);
	localparam int VAL_W       = 32;
	localparam int WORD_W      = 2 * VAL_W;
	localparam int DELTA_W     = 16;
	localparam int MAXV_W      = 31;
	localparam int STACK_DEPTH = $clog2(MAX_LEAVES) + 1;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_INVALID = 2'd1;
	localparam logic [1:0] STAT_WRAP    = 2'd2;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [1:0] {
		PH_LEFT,
		PH_RIGHT,
		PH_DONE
	} phase_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_VISIT,
		ST_CUPD,
		ST_PCHK,
		ST_PLW,
		ST_PRW,
		ST_PKW,
		ST_DESC,
		ST_RBA,
		ST_RBB,
		ST_RET,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic               action;
		logic [POS_W-1:0]   range_low;
		logic [POS_W-1:0]   range_high;
		logic [DELTA_W-1:0] delta;
	} item_t;

	typedef struct packed {
		logic              valid;
		logic [MAXV_W-1:0] max_value;
		logic [1:0]        status;
	} res_t;

endpackage

// ===== sv/lrm_ram.sv =====
module lrm_ram #(
	parameter int AW = 11,
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/lrm_core.sv =====
module lrm_core import lrm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [POS_W-1:0] size,
	input  logic             in_valid,
	output logic             in_ready,
	input  item_t            item,
	output res_t             res,
	input  logic             res_take
);

	state_t state_q, state_d;

	logic [NODE_AW-1:0] k_q;
	logic [POS_W-1:0]   l_q, r_q;
	phase_t             ph_q;
	logic [NODE_AW-1:0] stk_k_q [STACK_DEPTH];
	logic [POS_W-1:0]   stk_l_q [STACK_DEPTH];
	logic [POS_W-1:0]   stk_r_q [STACK_DEPTH];
	phase_t             stk_ph_q [STACK_DEPTH];
	logic [SP_W-1:0]    sp_q;

	logic             act_q;
	logic [POS_W-1:0] lo_q, hi_q;
	logic [VAL_W-1:0] delta_q, pend_q, kmax_q, a_q, best_q;
	logic             wrap_q;
	logic [1:0]       stat_q;
	logic [NODE_AW-1:0] clr_q;

	logic               we;
	logic [NODE_AW-1:0] waddr, raddr;
	logic [WORD_W-1:0]  wdata, rdata;

	lrm_ram #(.AW(NODE_AW), .DW(WORD_W)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// effective size and range check
	logic [POS_W-1:0] eff_size;
	logic             bad_range;
	always_comb begin
		if (size == '0) begin
			eff_size = POS_W'(1);
		end else if (size > POS_W'(MAX_LEAVES)) begin
			eff_size = POS_W'(MAX_LEAVES);
		end else begin
			eff_size = size;
		end
		bad_range = (item.range_low == '0) || (item.range_low > item.range_high) ||
			(item.range_high > eff_size);
	end

	// node geometry
	logic [POS_W:0]     lr_sum;
	logic [POS_W-1:0]   mid;
	logic [NODE_AW-1:0] k_left, k_right;
	logic               covered;
	assign lr_sum  = {1'b0, l_q} + {1'b0, r_q};
	assign mid     = lr_sum[POS_W:1];
	assign k_left  = {k_q[NODE_AW-2:0], 1'b0};
	assign k_right = {k_q[NODE_AW-2:0], 1'b1};
	assign covered = (l_q >= lo_q) && (r_q <= hi_q);

	// wrapping adds on the word just read
	logic [VAL_W-1:0] rd_max, rd_pend, addend, sum_max, sum_pend, rb_max;
	logic             ovf;
	assign rd_max   = rdata[WORD_W-1:VAL_W];
	assign rd_pend  = rdata[VAL_W-1:0];
	assign addend   = (state_q == ST_CUPD) ? delta_q : pend_q;
	assign sum_max  = rd_max + addend;
	assign sum_pend = rd_pend + addend;
	assign ovf      = ((rd_max ^ sum_max) & (addend ^ sum_max) & (VAL_W'(1) << (VAL_W - 1))) != '0 ||
		((rd_pend ^ sum_pend) & (addend ^ sum_pend) & (VAL_W'(1) << (VAL_W - 1))) != '0;
	assign rb_max   = ($signed(a_q) < $signed(rd_max)) ? rd_max : a_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_valid) state_d = bad_range ? ST_FIN : ST_VISIT;
			end
			ST_VISIT: state_d = covered ? ST_CUPD : ST_PCHK;
			ST_CUPD:  state_d = ST_RET;
			ST_PCHK:  state_d = (rd_pend == '0) ? ST_DESC : ST_PLW;
			ST_PLW:   state_d = ST_PRW;
			ST_PRW:   state_d = ST_PKW;
			ST_PKW:   state_d = ST_DESC;
			ST_DESC: begin
				case (ph_q)
					PH_LEFT:  if (lo_q <= mid) state_d = ST_VISIT;
					PH_RIGHT: if (hi_q > mid) state_d = ST_VISIT;
					default:  state_d = (act_q == ACT_ADD) ? ST_RBA : ST_RET;
				endcase
			end
			ST_RBA: state_d = ST_RBB;
			ST_RBB: state_d = ST_RET;
			ST_RET: state_d = (sp_q == '0) ? ST_FIN : ST_DESC;
			ST_FIN: if (res_take) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = k_q;
		wdata = '0;
		raddr = k_q;
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			ST_CUPD: begin
				we    = (act_q == ACT_ADD);
				wdata = {sum_max, sum_pend};
			end
			ST_PCHK: raddr = k_left;
			ST_PLW: begin
				we    = 1'b1;
				waddr = k_left;
				wdata = {sum_max, sum_pend};
				raddr = k_right;
			end
			ST_PRW: begin
				we    = 1'b1;
				waddr = k_right;
				wdata = {sum_max, sum_pend};
			end
			ST_PKW: begin
				we    = 1'b1;
				wdata = {kmax_q, VAL_W'(0)};
			end
			ST_DESC: raddr = k_left;
			ST_RBA:  raddr = k_right;
			ST_RBB: begin
				we    = 1'b1;
				wdata = {rb_max, VAL_W'(0)};
			end
			default: ;
		endcase
	end

	assign in_ready        = (state_q == ST_IDLE);
	assign res.valid       = (state_q == ST_FIN);
	assign res.max_value   = best_q[MAXV_W-1:0];
	assign res.status      = stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			sp_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_IDLE) sp_q <= '0;
			if (state_q == ST_DESC && state_d == ST_VISIT) sp_q <= sp_q + 1'b1;
			if (state_q == ST_RET && sp_q != '0) sp_q <= sp_q - 1'b1;
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				act_q   <= item.action;
				lo_q    <= item.range_low;
				hi_q    <= item.range_high;
				delta_q <= {{(VAL_W-DELTA_W){item.delta[DELTA_W-1]}}, item.delta};
				k_q     <= NODE_AW'(1);
				l_q     <= POS_W'(1);
				r_q     <= eff_size;
				ph_q    <= PH_LEFT;
				best_q  <= '0;
				wrap_q  <= 1'b0;
				stat_q  <= bad_range ? STAT_INVALID : STAT_OK;
			end
			ST_CUPD: begin
				if (act_q == ACT_ADD) begin
					if (ovf) wrap_q <= 1'b1;
				end else if ($signed(best_q) < $signed(rd_max)) begin
					best_q <= rd_max;
				end
			end
			ST_PCHK: begin
				pend_q <= rd_pend;
				kmax_q <= rd_max;
			end
			ST_PLW, ST_PRW: if (ovf) wrap_q <= 1'b1;
			ST_DESC: begin
				case (ph_q)
					PH_LEFT: begin
						if (lo_q <= mid) begin
							stk_k_q[sp_q]  <= k_q;
							stk_l_q[sp_q]  <= l_q;
							stk_r_q[sp_q]  <= r_q;
							stk_ph_q[sp_q] <= PH_RIGHT;
							k_q <= k_left;
							r_q <= mid;
						end else begin
							ph_q <= PH_RIGHT;
						end
					end
					PH_RIGHT: begin
						if (hi_q > mid) begin
							stk_k_q[sp_q]  <= k_q;
							stk_l_q[sp_q]  <= l_q;
							stk_r_q[sp_q]  <= r_q;
							stk_ph_q[sp_q] <= PH_DONE;
							k_q  <= k_right;
							l_q  <= mid + 1'b1;
							ph_q <= PH_LEFT;
						end else begin
							ph_q <= PH_DONE;
						end
					end
					default: ;
				endcase
			end
			ST_RBA: a_q <= rd_max;
			ST_RET: begin
				if (sp_q != '0) begin
					k_q  <= stk_k_q[sp_q - 1'b1];
					l_q  <= stk_l_q[sp_q - 1'b1];
					r_q  <= stk_r_q[sp_q - 1'b1];
					ph_q <= stk_ph_q[sp_q - 1'b1];
				end else begin
					if (act_q == ACT_ADD) best_q <= '0;
					stat_q <= wrap_q ? STAT_WRAP : STAT_OK;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/lazy_range_add_range_max_tree.sv =====
// lazy range-add / range-max tree over leaf positions 1..active_size
// input word (s_*): tuser = action (0 add, 1 query); tdata = range_low,
//   range_high, delta. output word (m_*): max_value and status.
// cfg_we/cfg_wdata writes active_size (reset 1); write it only while idle.
// each word walks the tree with a read-modify-write sequencer on one node
// memory (max and pending add per entry, one write and one read port):
//   a covered node is visited, updated by an add or read by a query, and
//   returned from; a split node is visited, checked for a pending add,
//   which is first pushed down into both children when nonzero, and then
//   descended. an add then rebuilds each split node's max from its children.
// an invalid range skips the walk. one word is in the walk at a time.
// after reset a clearing pass zeroes the 2048 node entries, one per cycle,
// so s_tready stays low until the pass ends; configuration writes are taken.
// the result goes to an output register; the next word is accepted while
// it waits, and a stalled m_tready holds only the finished walk behind it.
module lazy_range_add_range_max_tree import lrm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [POS_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [39:0]      s_tdata,  // range_low[10:0], range_high[21:11], delta[37:22]
	input  logic             s_tuser,  // action[0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [39:0]      m_tdata   // max_value[30:0], status[32:31]
);

	logic [POS_W-1:0]  size_q;
	item_t             item;
	res_t              res;
	logic              take;
	logic              m_valid_q;
	logic [MAXV_W-1:0] max_q;
	logic [1:0]        status_q;

	// size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= POS_W'(1);
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	assign item.action     = s_tuser;
	assign item.range_low  = s_tdata[10:0];
	assign item.range_high = s_tdata[21:11];
	assign item.delta      = s_tdata[37:22];

	lrm_core u_core (
		.clk(clk), .arst_n(arst_n), .size(size_q),
		.in_valid(s_tvalid), .in_ready(s_tready), .item(item),
		.res(res), .res_take(take)
	);

	// output register
	assign take = res.valid && (!m_valid_q || m_tready);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (take) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			max_q    <= res.max_value;
			status_q <= res.status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, status_q, max_q};

`include "lazy_range_add_range_max_tree_assert.svh"

	// one word in the walk at a time
	`LRM_ASSERT_NEXT(a_one_word, s_tvalid && s_tready, !s_tready)
	// a finished walk is held until the output register takes it
	`LRM_ASSERT_NEXT(a_res_hold, res.valid && !take, res.valid && $stable(res.max_value))
	// the core offers no result while it takes a word
	`LRM_ASSERT_NOW(a_res_idle, s_tready, !res.valid)

endmodule
